[hdl/m4inv_pkg.sv]
// Shared types, command codes and index helpers for the 4x4 matrix inverse block.
// Used by m4inv_ctrl, m4inv_dp and matrix4_inverse_cofactor; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package m4inv_pkg;

	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 40;
	localparam int unsigned ELEM_W     = 16;
	localparam int unsigned COF_W      = 49;
	localparam int unsigned DET_W      = 66;
	localparam int unsigned REM_W      = 99;
	localparam int unsigned QUO_W      = 33;

	localparam logic OPC_WRITE   = 1'b0;
	localparam logic OPC_COMPUTE = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_WRITE,
		OP_LOAD,
		OP_MUL,
		OP_ACC,
		OP_DMUL,
		OP_DACC,
		OP_DPREP,
		OP_DLOAD,
		OP_DCHK,
		OP_DSTEP,
		OP_DOUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [3:0] rd_addr;
		logic [3:0] cof_addr;
		logic [3:0] out_idx;
		logic       first;
		logic       last;
		logic       neg;
	} dp_cmd_t;

	typedef struct packed {
		logic sing;
		logic out_free;
	} dp_stat_t;

	// Index k of the kept rows or columns once index i is struck out.
	function automatic logic [1:0] skip_idx(input logic [1:0] i, input logic [1:0] k);
		return (k < i) ? k : k + 2'd1;
	endfunction

	// Column taken in row k of the 3x3 minor by term t of the Leibniz expansion.
	// Terms 0 to 2 are even permutations, terms 3 to 5 odd.
	function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] k);
		logic [7:0] p;
		case (t)
			3'd0:    p = 8'b00_10_01_00;
			3'd1:    p = 8'b00_00_10_01;
			3'd2:    p = 8'b00_01_00_10;
			3'd3:    p = 8'b00_01_10_00;
			3'd4:    p = 8'b00_10_00_01;
			3'd5:    p = 8'b00_00_01_10;
			default: p = 8'b0;
		endcase
		return p[{k, 1'b0} +: 2];
	endfunction

	// Matrix address of factor k of term t of the cofactor at position ent.
	function automatic logic [3:0] elem_addr(input logic [3:0] ent, input logic [2:0] t,
			input logic [1:0] k);
		logic [1:0] pc;
		logic [1:0] r;
		logic [1:0] c;
		pc = perm_col(t, k);
		r  = skip_idx(ent[3:2], k);
		c  = skip_idx(ent[1:0], pc);
		return {r, c};
	endfunction

endpackage
`default_nettype wire

[hdl/m4inv_ctrl.sv]
// Sequencer for the 4x4 matrix inverse: walks cofactors, determinant, division and output.
// Depends on m4inv_pkg; drives m4inv_dp through dp_cmd_t and reads dp_stat_t.
`timescale 1ns / 1ps
`default_nettype none
module m4inv_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire                 in_opcode,
	output logic                in_ready,
	output m4inv_pkg::dp_cmd_t  cmd,
	input  m4inv_pkg::dp_stat_t stat
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_COF   = 9'b000000010,
		ST_DMUL  = 9'b000000100,
		ST_DACC  = 9'b000001000,
		ST_DPREP = 9'b000010000,
		ST_LOAD  = 9'b000100000,
		ST_CHK   = 9'b001000000,
		ST_STEP  = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t     state_q;
	logic [3:0] ent_q;
	logic [2:0] term_q;
	logic [1:0] step_q;
	logic [5:0] bit_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.op       = m4inv_pkg::OP_NONE;
		cmd.out_idx  = ent_q;
		cmd.rd_addr  = m4inv_pkg::elem_addr(ent_q, term_q, step_q);
		cmd.cof_addr = ent_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_opcode == m4inv_pkg::OPC_WRITE)
					cmd.op = m4inv_pkg::OP_WRITE;
			end
			ST_COF: begin
				case (step_q)
					2'd0:    cmd.op = m4inv_pkg::OP_LOAD;
					2'd3:    cmd.op = m4inv_pkg::OP_ACC;
					default: cmd.op = m4inv_pkg::OP_MUL;
				endcase
				cmd.first = (term_q == 3'd0);
				cmd.last  = (term_q == 3'd5);
				// Odd permutation flips the term; odd row plus column flips the cofactor.
				cmd.neg   = (term_q >= 3'd3) ^ ent_q[2] ^ ent_q[0];
			end
			ST_DMUL: begin
				cmd.op       = m4inv_pkg::OP_DMUL;
				cmd.rd_addr  = {2'b00, ent_q[1:0]};
				cmd.cof_addr = {2'b00, ent_q[1:0]};
			end
			ST_DACC: begin
				cmd.op    = m4inv_pkg::OP_DACC;
				cmd.first = (ent_q[1:0] == 2'd0);
			end
			ST_DPREP: cmd.op = m4inv_pkg::OP_DPREP;
			ST_LOAD: begin
				cmd.op       = m4inv_pkg::OP_DLOAD;
				cmd.cof_addr = {ent_q[1:0], ent_q[3:2]};
			end
			ST_CHK:  cmd.op = m4inv_pkg::OP_DCHK;
			ST_STEP: cmd.op = m4inv_pkg::OP_DSTEP;
			ST_OUT: begin
				if (stat.out_free)
					cmd.op = m4inv_pkg::OP_DOUT;
				cmd.last = (ent_q == 4'd15);
			end
			default: cmd.op = m4inv_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ent_q   <= '0;
			term_q  <= '0;
			step_q  <= '0;
			bit_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_opcode == m4inv_pkg::OPC_COMPUTE) begin
						state_q <= ST_COF;
						ent_q   <= '0;
						term_q  <= '0;
						step_q  <= '0;
					end
				end
				ST_COF: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						if (term_q == 3'd5) begin
							term_q <= '0;
							ent_q  <= ent_q + 4'd1;
							if (ent_q == 4'd15)
								state_q <= ST_DMUL;
						end else begin
							term_q <= term_q + 3'd1;
						end
					end
				end
				ST_DMUL: state_q <= ST_DACC;
				ST_DACC: begin
					if (ent_q[1:0] == 2'd3) begin
						ent_q   <= '0;
						state_q <= ST_DPREP;
					end else begin
						ent_q   <= ent_q + 4'd1;
						state_q <= ST_DMUL;
					end
				end
				ST_DPREP: state_q <= ST_LOAD;
				ST_LOAD: begin
					// A singular matrix needs no division: all entries are zero.
					if (stat.sing)
						state_q <= ST_OUT;
					else
						state_q <= ST_CHK;
				end
				ST_CHK: begin
					bit_q   <= '0;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					bit_q <= bit_q + 6'd1;
					if (bit_q == 6'(m4inv_pkg::QUO_W - 1))
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (stat.out_free) begin
						ent_q <= ent_q + 4'd1;
						if (ent_q == 4'd15)
							state_q <= ST_IDLE;
						else
							state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[hdl/m4inv_dp.sv]
// Datapath of the 4x4 matrix inverse: matrix store, product chain, cofactors,
// determinant, restoring divider and output register. Depends on m4inv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module m4inv_dp (
	input  wire                       clk,
	input  wire                       arst_n,
	input  m4inv_pkg::dp_cmd_t        cmd,
	output m4inv_pkg::dp_stat_t       stat,
	input  wire [1:0]                 wr_row,
	input  wire [1:0]                 wr_col,
	input  wire signed [m4inv_pkg::ELEM_W-1:0] wr_data,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic [1:0]                out_row,
	output logic [1:0]                out_col,
	output logic [31:0]               out_value,
	output logic                      out_singular,
	output logic                      out_saturated,
	output logic                      out_last
);

	localparam int unsigned CW = m4inv_pkg::COF_W;
	localparam int unsigned DW = m4inv_pkg::DET_W;
	localparam int unsigned RW = m4inv_pkg::REM_W;
	localparam int unsigned QW = m4inv_pkg::QUO_W;

	logic signed [15:0]   mat_q [16];
	logic signed [CW-1:0] cof_q [16];
	logic signed [63:0]   p_q;
	logic signed [CW-1:0] acc_q;
	logic signed [DW-1:0] det_q;
	logic [DW-1:0]        dmag_q;
	logic                 dneg_q;
	logic                 sing_q;
	logic [RW-1:0]        rem_q;
	logic [RW-1:0]        dsh_q;
	logic [QW-1:0]        quo_q;
	logic                 qneg_q;
	logic                 ovf_q;

	logic signed [15:0]   elem;
	logic signed [CW-1:0] cof_rd;
	logic signed [47:0]   mul_p;
	logic signed [64:0]   mul_d;
	logic signed [CW-1:0] acc_sum;
	logic [47:0]          cof_mag;
	logic                 rem_ge;
	logic [31:0]          val_d;
	logic                 sat_d;

	assign elem   = mat_q[cmd.rd_addr];
	assign cof_rd = cof_q[cmd.cof_addr];
	assign mul_p  = $signed(p_q[31:0]) * elem;
	assign mul_d  = cof_rd * elem;
	assign rem_ge = (rem_q >= dsh_q);

	always_comb begin
		if (cmd.neg)
			acc_sum = (cmd.first ? '0 : acc_q) - p_q[CW-1:0];
		else
			acc_sum = (cmd.first ? '0 : acc_q) + p_q[CW-1:0];
	end

	always_comb begin
		logic [CW-1:0] m;
		m       = cof_rd[CW-1] ? -cof_rd : cof_rd;
		cof_mag = m[47:0];
	end

	always_comb begin
		val_d = '0;
		sat_d = 1'b0;
		if (!sing_q) begin
			if (!qneg_q) begin
				if (ovf_q || quo_q > QW'(32'h7FFF_FFFF)) begin
					val_d = 32'h7FFF_FFFF;
					sat_d = 1'b1;
				end else begin
					val_d = quo_q[31:0];
				end
			end else begin
				if (ovf_q || quo_q > QW'(32'h8000_0000)) begin
					val_d = 32'h8000_0000;
					sat_d = 1'b1;
				end else begin
					val_d = -quo_q[31:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			m4inv_pkg::OP_WRITE: mat_q[{wr_row, wr_col}] <= wr_data;
			m4inv_pkg::OP_LOAD:  p_q <= 64'(elem);
			m4inv_pkg::OP_MUL:   p_q <= 64'(mul_p);
			m4inv_pkg::OP_ACC: begin
				acc_q <= acc_sum;
				if (cmd.last)
					cof_q[cmd.cof_addr] <= acc_sum;
			end
			m4inv_pkg::OP_DMUL:  p_q <= mul_d[63:0];
			m4inv_pkg::OP_DACC:  det_q <= (cmd.first ? '0 : det_q) + DW'(p_q);
			m4inv_pkg::OP_DPREP: begin
				dneg_q <= det_q[DW-1];
				dmag_q <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
			end
			m4inv_pkg::OP_DLOAD: begin
				rem_q  <= RW'(cof_mag) << 24;
				dsh_q  <= {dmag_q, {QW{1'b0}}};
				quo_q  <= '0;
				qneg_q <= cof_rd[CW-1] ^ dneg_q;
			end
			m4inv_pkg::OP_DCHK: begin
				// A quotient of 2^33 or more saturates whatever its sign.
				ovf_q <= rem_ge;
				dsh_q <= dsh_q >> 1;
			end
			m4inv_pkg::OP_DSTEP: begin
				if (rem_ge)
					rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[QW-2:0], rem_ge};
				dsh_q <= dsh_q >> 1;
			end
			m4inv_pkg::OP_DOUT: begin
				out_row       <= cmd.out_idx[3:2];
				out_col       <= cmd.out_idx[1:0];
				out_value     <= val_d;
				out_singular  <= sing_q;
				out_saturated <= sat_d;
				out_last      <= cmd.last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			sing_q    <= 1'b0;
		end else begin
			if (cmd.op == m4inv_pkg::OP_DPREP)
				sing_q <= (det_q == '0);
			if (cmd.op == m4inv_pkg::OP_DOUT)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	assign stat.sing     = sing_q;
	assign stat.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

[hdl/matrix4_inverse_cofactor.sv]
// Top level of the 4x4 fixed-point matrix inverse by cofactors.
// Depends on m4inv_pkg, m4inv_ctrl and m4inv_dp.
`timescale 1ns / 1ps
`default_nettype none
// A write beat (tuser 0) stores one Q8.8 element. A compute beat (tuser 1)
// forms the 16 cofactors with one shared 32x16 multiplier, then the
// determinant, then divides each cofactor by the determinant with a
// one-bit-per-cycle restoring divider; a singular matrix skips the division
// and any output stall holds the sequence. The sixteen Q16.16 result beats
// leave in row-major order through an output register; the input side
// accepts again once the last one has been loaded. Reading an element never
// written gives undefined results.
module matrix4_inverse_cofactor (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	// row_index[1:0], col_index[3:2], element_value[19:4]
	input  wire [m4inv_pkg::IN_DATA_W-1:0] s_tdata,
	input  wire        s_tuser,   // opcode
	output logic       m_tvalid,
	input  wire        m_tready,
	// out_row[1:0], out_col[3:2], inverse_value[35:4]
	output logic [m4inv_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [1:0] m_tuser,   // singular[0], saturated[1]
	output logic       m_tlast
);

	m4inv_pkg::dp_cmd_t  cmd;
	m4inv_pkg::dp_stat_t stat;
	logic [1:0]          o_row;
	logic [1:0]          o_col;
	logic [31:0]         o_val;
	logic                o_sing;
	logic                o_sat;

	m4inv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_opcode(s_tuser),
		.in_ready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	m4inv_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.wr_row       (s_tdata[1:0]),
		.wr_col       (s_tdata[3:2]),
		.wr_data      ($signed(s_tdata[19:4])),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_row      (o_row),
		.out_col      (o_col),
		.out_value    (o_val),
		.out_singular (o_sing),
		.out_saturated(o_sat),
		.out_last     (m_tlast)
	);

	assign m_tdata = {4'b0000, o_val, o_col, o_row};
	assign m_tuser = {o_sat, o_sing};

endmodule
`default_nettype wire
